### rtl/core/rv32i_execute_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RV32I execute unit
// Concurrent checks sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_UNIT_ASSERT_SVH
`define RV32I_EXECUTE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("execute unit check failed");

// Consequent must hold in the cycle after the antecedent.
`define EU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("execute unit check failed");

`endif

### rtl/core/rv32i_eu_pkg.sv
// ---------------------------------------------------------------------------
// RV32I execute unit package
// Instruction kinds, result codes and the execute result bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package rv32i_eu_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned RF_AW = $clog2(REG_COUNT);
  localparam logic [31:0] START_ADDRESS = 32'h0000_0000;

  localparam logic [1:0] PRIV_USER       = 2'd0;
  localparam logic [1:0] PRIV_SUPERVISOR = 2'd1;
  localparam logic [1:0] PRIV_MACHINE    = 2'd3;

  localparam logic [3:0] CAUSE_NONE       = 4'd0;
  localparam logic [3:0] CAUSE_BREAKPOINT = 4'd3;
  localparam logic [3:0] CAUSE_ECALL_U    = 4'd8;
  localparam logic [3:0] CAUSE_ECALL_S    = 4'd9;
  localparam logic [3:0] CAUSE_ECALL_M    = 4'd11;

  typedef enum logic [5:0] {
    CMD_LUI    = 6'd0,  CMD_AUIPC = 6'd1,  CMD_JAL   = 6'd2,  CMD_JALR  = 6'd3,
    CMD_BEQ    = 6'd4,  CMD_BNE   = 6'd5,  CMD_BLT   = 6'd6,  CMD_BGE   = 6'd7,
    CMD_BLTU   = 6'd8,  CMD_BGEU  = 6'd9,
    CMD_LB     = 6'd10, CMD_LBU   = 6'd11, CMD_LH    = 6'd12, CMD_LHU   = 6'd13,
    CMD_LW     = 6'd14, CMD_SB    = 6'd15, CMD_SH    = 6'd16, CMD_SW    = 6'd17,
    CMD_ADDI   = 6'd18, CMD_SLTI  = 6'd19, CMD_SLTIU = 6'd20, CMD_XORI  = 6'd21,
    CMD_ORI    = 6'd22, CMD_ANDI  = 6'd23,
    CMD_SLLI   = 6'd24, CMD_SRLI  = 6'd25, CMD_SRAI  = 6'd26,
    CMD_ADD    = 6'd27, CMD_SUB   = 6'd28, CMD_SLL   = 6'd29, CMD_SLT   = 6'd30,
    CMD_SLTU   = 6'd31, CMD_XOR   = 6'd32, CMD_SRL   = 6'd33, CMD_SRA   = 6'd34,
    CMD_OR     = 6'd35, CMD_AND   = 6'd36,
    CMD_FENCE  = 6'd37, CMD_ECALL = 6'd38, CMD_EBREAK = 6'd39, CMD_WFI  = 6'd40
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FAULT = 2'd1,
    STATUS_TRAP  = 2'd2,
    STATUS_WFI   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } mem_size_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] npc;
    logic        wr;
    logic [31:0] wval;
    mem_op_e     mop;
    mem_size_e   msize;
    logic [31:0] maddr;
    logic [31:0] sval;
    logic [3:0]  cause;
  } exec_res_t;

endpackage

`default_nettype wire

### rtl/core/rv32i_eu_exec.sv
// ---------------------------------------------------------------------------
// RV32I execute datapath
// ALU, shifts, compares, branch and jump targets, load extension, store
// masking and trap cause selection for one instruction.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32i_eu_exec (
  input  logic [5:0]                cmd_i,
  input  logic [4:0]                rd_idx_i,
  input  logic [31:0]               rs1_val_i,
  input  logic [31:0]               rs2_val_i,
  input  logic [31:0]               imm_i,
  input  logic [2:0]                len_i,
  input  logic [31:0]               load_data_i,
  input  logic                      bus_ok_i,
  input  logic [31:0]               pc_i,
  input  logic [1:0]                priv_i,
  output rv32i_eu_pkg::exec_res_t   res_o
);

  logic [31:0] seq_pc;
  logic [31:0] pc_rel;
  logic [31:0] rs1_imm;
  logic [4:0]  sh_imm;
  logic [4:0]  sh_reg;
  logic        lt_signed;
  logic        lt_unsigned;
  logic        rd_ok;
  rv32i_eu_pkg::exec_res_t r;

  assign seq_pc      = pc_i + {29'd0, len_i};
  assign pc_rel      = pc_i + imm_i;
  assign rs1_imm     = rs1_val_i + imm_i;
  assign sh_imm      = imm_i[4:0];
  assign sh_reg      = rs2_val_i[4:0];
  assign lt_signed   = $signed(rs1_val_i) < $signed(rs2_val_i);
  assign lt_unsigned = rs1_val_i < rs2_val_i;
  assign rd_ok       = (rd_idx_i != 5'd0) &&
                       ({1'b0, rd_idx_i} < 6'(rv32i_eu_pkg::REG_COUNT));

  always_comb begin
    r        = '0;
    r.status = rv32i_eu_pkg::STATUS_OK;
    r.mop    = rv32i_eu_pkg::MEM_NONE;
    r.msize  = rv32i_eu_pkg::SIZE_BYTE;
    r.cause  = rv32i_eu_pkg::CAUSE_NONE;
    r.npc    = seq_pc;
    case (rv32i_eu_pkg::cmd_e'(cmd_i))
      rv32i_eu_pkg::CMD_LUI:   begin r.wr = 1'b1; r.wval = imm_i; end
      rv32i_eu_pkg::CMD_AUIPC: begin r.wr = 1'b1; r.wval = pc_rel; end
      rv32i_eu_pkg::CMD_JAL: begin
        r.wr = 1'b1; r.wval = seq_pc; r.npc = pc_rel;
      end
      rv32i_eu_pkg::CMD_JALR: begin
        r.wr = 1'b1; r.wval = seq_pc; r.npc = {rs1_imm[31:1], 1'b0};
      end
      rv32i_eu_pkg::CMD_BEQ:  if (rs1_val_i == rs2_val_i) r.npc = pc_rel;
      rv32i_eu_pkg::CMD_BNE:  if (rs1_val_i != rs2_val_i) r.npc = pc_rel;
      rv32i_eu_pkg::CMD_BLT:  if (lt_signed) r.npc = pc_rel;
      rv32i_eu_pkg::CMD_BGE:  if (!lt_signed) r.npc = pc_rel;
      rv32i_eu_pkg::CMD_BLTU: if (lt_unsigned) r.npc = pc_rel;
      rv32i_eu_pkg::CMD_BGEU: if (!lt_unsigned) r.npc = pc_rel;
      rv32i_eu_pkg::CMD_LB, rv32i_eu_pkg::CMD_LBU, rv32i_eu_pkg::CMD_LH,
      rv32i_eu_pkg::CMD_LHU, rv32i_eu_pkg::CMD_LW: begin
        r.mop   = rv32i_eu_pkg::MEM_READ;
        r.maddr = rs1_imm;
        r.wr    = bus_ok_i;
        case (rv32i_eu_pkg::cmd_e'(cmd_i))
          rv32i_eu_pkg::CMD_LB: begin
            r.msize = rv32i_eu_pkg::SIZE_BYTE;
            r.wval  = {{24{load_data_i[7]}}, load_data_i[7:0]};
          end
          rv32i_eu_pkg::CMD_LBU: begin
            r.msize = rv32i_eu_pkg::SIZE_BYTE;
            r.wval  = {24'd0, load_data_i[7:0]};
          end
          rv32i_eu_pkg::CMD_LH: begin
            r.msize = rv32i_eu_pkg::SIZE_HALF;
            r.wval  = {{16{load_data_i[15]}}, load_data_i[15:0]};
          end
          rv32i_eu_pkg::CMD_LHU: begin
            r.msize = rv32i_eu_pkg::SIZE_HALF;
            r.wval  = {16'd0, load_data_i[15:0]};
          end
          default: begin
            r.msize = rv32i_eu_pkg::SIZE_WORD;
            r.wval  = load_data_i;
          end
        endcase
        if (!bus_ok_i) begin
          r.status = rv32i_eu_pkg::STATUS_FAULT;
          r.npc    = pc_i;
        end
      end
      rv32i_eu_pkg::CMD_SB, rv32i_eu_pkg::CMD_SH, rv32i_eu_pkg::CMD_SW: begin
        r.mop   = rv32i_eu_pkg::MEM_WRITE;
        r.maddr = rs1_imm;
        case (rv32i_eu_pkg::cmd_e'(cmd_i))
          rv32i_eu_pkg::CMD_SB: begin
            r.msize = rv32i_eu_pkg::SIZE_BYTE;
            r.sval  = {24'd0, rs2_val_i[7:0]};
          end
          rv32i_eu_pkg::CMD_SH: begin
            r.msize = rv32i_eu_pkg::SIZE_HALF;
            r.sval  = {16'd0, rs2_val_i[15:0]};
          end
          default: begin
            r.msize = rv32i_eu_pkg::SIZE_WORD;
            r.sval  = rs2_val_i;
          end
        endcase
        if (!bus_ok_i) begin
          r.status = rv32i_eu_pkg::STATUS_FAULT;
          r.npc    = pc_i;
        end
      end
      rv32i_eu_pkg::CMD_ADDI:  begin r.wr = 1'b1; r.wval = rs1_imm; end
      rv32i_eu_pkg::CMD_SLTI: begin
        r.wr = 1'b1; r.wval = {31'd0, $signed(rs1_val_i) < $signed(imm_i)};
      end
      rv32i_eu_pkg::CMD_SLTIU: begin
        r.wr = 1'b1; r.wval = {31'd0, rs1_val_i < imm_i};
      end
      rv32i_eu_pkg::CMD_XORI:  begin r.wr = 1'b1; r.wval = rs1_val_i ^ imm_i; end
      rv32i_eu_pkg::CMD_ORI:   begin r.wr = 1'b1; r.wval = rs1_val_i | imm_i; end
      rv32i_eu_pkg::CMD_ANDI:  begin r.wr = 1'b1; r.wval = rs1_val_i & imm_i; end
      rv32i_eu_pkg::CMD_SLLI:  begin r.wr = 1'b1; r.wval = rs1_val_i << sh_imm; end
      rv32i_eu_pkg::CMD_SRLI:  begin r.wr = 1'b1; r.wval = rs1_val_i >> sh_imm; end
      rv32i_eu_pkg::CMD_SRAI: begin
        r.wr = 1'b1; r.wval = $unsigned($signed(rs1_val_i) >>> sh_imm);
      end
      rv32i_eu_pkg::CMD_ADD:   begin r.wr = 1'b1; r.wval = rs1_val_i + rs2_val_i; end
      rv32i_eu_pkg::CMD_SUB:   begin r.wr = 1'b1; r.wval = rs1_val_i - rs2_val_i; end
      rv32i_eu_pkg::CMD_SLL:   begin r.wr = 1'b1; r.wval = rs1_val_i << sh_reg; end
      rv32i_eu_pkg::CMD_SLT:   begin r.wr = 1'b1; r.wval = {31'd0, lt_signed}; end
      rv32i_eu_pkg::CMD_SLTU:  begin r.wr = 1'b1; r.wval = {31'd0, lt_unsigned}; end
      rv32i_eu_pkg::CMD_XOR:   begin r.wr = 1'b1; r.wval = rs1_val_i ^ rs2_val_i; end
      rv32i_eu_pkg::CMD_SRL:   begin r.wr = 1'b1; r.wval = rs1_val_i >> sh_reg; end
      rv32i_eu_pkg::CMD_SRA: begin
        r.wr = 1'b1; r.wval = $unsigned($signed(rs1_val_i) >>> sh_reg);
      end
      rv32i_eu_pkg::CMD_OR:    begin r.wr = 1'b1; r.wval = rs1_val_i | rs2_val_i; end
      rv32i_eu_pkg::CMD_AND:   begin r.wr = 1'b1; r.wval = rs1_val_i & rs2_val_i; end
      rv32i_eu_pkg::CMD_FENCE: begin end
      rv32i_eu_pkg::CMD_ECALL: begin
        r.status = rv32i_eu_pkg::STATUS_TRAP;
        r.npc    = pc_i;
        if (priv_i == rv32i_eu_pkg::PRIV_USER) begin
          r.cause = rv32i_eu_pkg::CAUSE_ECALL_U;
        end else if (priv_i == rv32i_eu_pkg::PRIV_SUPERVISOR) begin
          r.cause = rv32i_eu_pkg::CAUSE_ECALL_S;
        end else begin
          r.cause = rv32i_eu_pkg::CAUSE_ECALL_M;
        end
      end
      rv32i_eu_pkg::CMD_EBREAK: begin
        r.status = rv32i_eu_pkg::STATUS_TRAP;
        r.npc    = pc_i;
        r.cause  = rv32i_eu_pkg::CAUSE_BREAKPOINT;
      end
      rv32i_eu_pkg::CMD_WFI: r.status = rv32i_eu_pkg::STATUS_WFI;
      default: begin
        r.status = rv32i_eu_pkg::STATUS_FAULT;
        r.npc    = pc_i;
      end
    endcase
    // drop writes to x0 and to registers beyond the file
    if (!(r.wr && rd_ok)) begin
      r.wr   = 1'b0;
      r.wval = '0;
    end
  end

  assign res_o = r;

endmodule

`default_nettype wire

### rtl/core/rv32i_execute_unit.sv
// ---------------------------------------------------------------------------
// RV32I execute unit: input beat to execute register, result to output register.
// One instruction per cycle unless stalled, set by the single execute register.
// Reset: registers read zero (valid bits), PC at START_ADDRESS, machine mode.
// ---------------------------------------------------------------------------
`default_nettype none

module rv32i_execute_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [5:0]         command_i,
  input  logic [4:0]         dest_index_i,
  input  logic [4:0]         src1_index_i,
  input  logic [4:0]         src2_index_i,
  input  logic signed [31:0] immediate_i,
  input  logic [2:0]         insn_length_i,
  input  logic [31:0]        load_data_i,
  input  logic               bus_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        new_pc_o,
  output logic               reg_written_o,
  output logic [31:0]        written_value_o,
  output logic [1:0]         mem_op_o,
  output logic [1:0]         mem_size_o,
  output logic [31:0]        mem_address_o,
  output logic [31:0]        store_value_o,
  output logic [3:0]         trap_cause_o
);

  localparam int unsigned AW = rv32i_eu_pkg::RF_AW;

  // control state
  logic                              ex_valid_q;
  logic                              out_valid_q;
  logic [31:0]                       pc_q;
  logic [1:0]                        priv_q;
  logic [rv32i_eu_pkg::REG_COUNT-1:0] rf_vld_q;

  // execute register payload
  logic [5:0]  cmd_q;
  logic [4:0]  rd_q;
  logic [31:0] imm_q;
  logic [2:0]  len_q;
  logic [31:0] ldata_q;
  logic        bus_ok_q;
  logic [31:0] rs1_raw_q, rs2_raw_q;
  logic        rs1_fwd_q, rs2_fwd_q;
  logic        rs1_zero_q, rs2_zero_q;
  logic [31:0] fwd_val_q;

  logic [31:0] rf_mem [rv32i_eu_pkg::REG_COUNT];

  rv32i_eu_pkg::exec_res_t res;
  rv32i_eu_pkg::exec_res_t out_q;

  logic        in_accept;
  logic        ex_fire;
  logic [31:0] rs1_val, rs2_val;
  logic        fwd1, fwd2;
  logic        zero1, zero2;

  assign ex_fire    = ex_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !ex_valid_q || ex_fire;
  assign in_accept  = in_valid_i && in_ready_o;

  // the instruction leaving execute writes the file on this same edge: forward it
  assign fwd1  = ex_fire && res.wr && (rd_q == src1_index_i);
  assign fwd2  = ex_fire && res.wr && (rd_q == src2_index_i);
  assign zero1 = (src1_index_i == 5'd0) ||
                 ({1'b0, src1_index_i} >= 6'(rv32i_eu_pkg::REG_COUNT)) ||
                 !rf_vld_q[src1_index_i[AW-1:0]];
  assign zero2 = (src2_index_i == 5'd0) ||
                 ({1'b0, src2_index_i} >= 6'(rv32i_eu_pkg::REG_COUNT)) ||
                 !rf_vld_q[src2_index_i[AW-1:0]];

  assign rs1_val = rs1_fwd_q ? fwd_val_q : (rs1_zero_q ? 32'd0 : rs1_raw_q);
  assign rs2_val = rs2_fwd_q ? fwd_val_q : (rs2_zero_q ? 32'd0 : rs2_raw_q);

  rv32i_eu_exec u_exec (
    .cmd_i       (cmd_q),
    .rd_idx_i    (rd_q),
    .rs1_val_i   (rs1_val),
    .rs2_val_i   (rs2_val),
    .imm_i       (imm_q),
    .len_i       (len_q),
    .load_data_i (ldata_q),
    .bus_ok_i    (bus_ok_q),
    .pc_i        (pc_q),
    .priv_i      (priv_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= rv32i_eu_pkg::START_ADDRESS;
      priv_q      <= rv32i_eu_pkg::PRIV_MACHINE;
      rf_vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        priv_q <= cfg_data_i;
      end
      if (in_accept) begin
        ex_valid_q <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_q <= 1'b1;
        pc_q        <= res.npc;
        if (res.wr) begin
          rf_vld_q[rd_q[AW-1:0]] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // register file and payload registers
  always_ff @(posedge clk_i) begin
    if (ex_fire && res.wr) begin
      rf_mem[rd_q[AW-1:0]] <= res.wval;
    end
    if (in_accept) begin
      cmd_q      <= command_i;
      rd_q       <= dest_index_i;
      imm_q      <= $unsigned(immediate_i);
      len_q      <= insn_length_i;
      ldata_q    <= load_data_i;
      bus_ok_q   <= bus_ok_i;
      rs1_raw_q  <= rf_mem[src1_index_i[AW-1:0]];
      rs2_raw_q  <= rf_mem[src2_index_i[AW-1:0]];
      rs1_fwd_q  <= fwd1;
      rs2_fwd_q  <= fwd2;
      rs1_zero_q <= zero1;
      rs2_zero_q <= zero2;
      fwd_val_q  <= res.wval;
    end
    if (ex_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign new_pc_o        = out_q.npc;
  assign reg_written_o   = out_q.wr;
  assign written_value_o = out_q.wval;
  assign mem_op_o        = out_q.mop;
  assign mem_size_o      = out_q.msize;
  assign mem_address_o   = out_q.maddr;
  assign store_value_o   = out_q.sval;
  assign trap_cause_o    = out_q.cause;

endmodule

`default_nettype wire

### rtl/core/rv32i_eu_checker.sv
// ---------------------------------------------------------------------------
// RV32I execute unit port checker
// Watches the result beat for consistency between its fields over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rv32i_execute_unit_assert.svh"

module rv32i_eu_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [1:0]         status_o,
  input  logic [31:0]        new_pc_o,
  input  logic               reg_written_o,
  input  logic [1:0]         mem_op_o,
  input  logic [31:0]        mem_address_o,
  input  logic [31:0]        store_value_o,
  input  logic [3:0]         trap_cause_o
);

  logic stall;
  assign stall = out_valid_o && !out_ready_i;

  // a stalled result beat holds
  `EU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, out_valid_o && $stable(new_pc_o))

  // only a clean instruction writes back
  `EU_ASSERT_SAME(a_wr_ok, clk_i, rst_ni, out_valid_o && reg_written_o,
                  status_o == rv32i_eu_pkg::STATUS_OK)

  // no memory access means an empty request
  `EU_ASSERT_SAME(a_mem_idle, clk_i, rst_ni,
                  out_valid_o && mem_op_o == rv32i_eu_pkg::MEM_NONE,
                  mem_address_o == 32'd0 && store_value_o == 32'd0)

  // a cause only comes with a trap
  `EU_ASSERT_SAME(a_cause_trap, clk_i, rst_ni,
                  out_valid_o && status_o != rv32i_eu_pkg::STATUS_TRAP,
                  trap_cause_o == rv32i_eu_pkg::CAUSE_NONE)

endmodule

bind rv32i_execute_unit rv32i_eu_checker u_checker (.*);

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RV32I execute unit testbench
// A table of directed instructions is followed by random programmes, run
// under four privilege settings, all but the last two with random idling on
// both sides. A local model of the register file and PC predicts each result,
// and every result beat is compared in order against it or a typed row.
// ---------------------------------------------------------------------------

module testbench;

  import rv32i_eu_pkg::*;

  localparam logic [1:0] PRIV_RESERVED   = 2'd2;
  localparam logic [5:0] CMD_UNKNOWN_LO  = 6'd41;
  localparam logic [5:0] CMD_UNKNOWN_HI  = 6'd63;
  localparam int         HOLD_CYCLES     = 60;
  localparam int         SETTLE_CYCLES   = 6;
  localparam int         QUIET_LIMIT     = 1000;
  localparam int         REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [2:0]  len;
    logic [31:0] ldata;
    logic        ok;
  } insn_t;

  typedef struct {
    insn_t      insn;
    bit         typed;
    exec_res_t  res;
  } insn_row_t;

  localparam exec_res_t NO_CHECK = '0;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [5:0]         command_i;
  logic [4:0]         dest_index_i;
  logic [4:0]         src1_index_i;
  logic [4:0]         src2_index_i;
  logic signed [31:0] immediate_i;
  logic [2:0]         insn_length_i;
  logic [31:0]        load_data_i;
  logic               bus_ok_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [31:0]        new_pc_o;
  logic               reg_written_o;
  logic [31:0]        written_value_o;
  logic [1:0]         mem_op_o;
  logic [1:0]         mem_size_o;
  logic [31:0]        mem_address_o;
  logic [31:0]        store_value_o;
  logic [3:0]         trap_cause_o;

  // Architectural state as the bench sees it
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [1:0]  priv_mode;

  exec_res_t predicted_retires [$];
  int        mismatches     = 0;
  int        retired        = 0;
  int        quiet_cycles   = 0;
  int        send_gap_pct   = 9;
  int        recv_stall_pct = 65;
  bit        hold_request   = 1'b0;

  // Directed programme; typed rows assume PC starts at zero in machine mode
  insn_row_t directed_rows [25] = '{
    '{'{CMD_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 3'd4, 32'd0, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd4, 1'b1, 32'h8000_0000, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_NONE}},
    '{'{CMD_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, 3'd4, 32'd0, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd8, 1'b1, 32'hFFFF_FFFF, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_NONE}},
    '{'{CMD_ADDI, 5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF, 3'd4, 32'd0, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd12, 1'b1, 32'h7FFF_FFFF, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_NONE}},
    '{'{CMD_LB, 5'd4, 5'd0, 5'd0, 32'h100, 3'd4, 32'h0000_0080, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd16, 1'b1, 32'hFFFF_FF80, MEM_READ, SIZE_BYTE, 32'h100, 32'd0, CAUSE_NONE}},
    '{'{CMD_LBU, 5'd5, 5'd0, 5'd0, 32'h101, 3'd4, 32'hFFFF_FF80, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd20, 1'b1, 32'h80, MEM_READ, SIZE_BYTE, 32'h101, 32'd0, CAUSE_NONE}},
    '{'{CMD_LH, 5'd6, 5'd0, 5'd0, 32'h102, 3'd4, 32'h0000_8000, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd24, 1'b1, 32'hFFFF_8000, MEM_READ, SIZE_HALF, 32'h102, 32'd0, CAUSE_NONE}},
    '{'{CMD_LHU, 5'd7, 5'd0, 5'd0, 32'h104, 3'd4, 32'hFFFF_8000, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd28, 1'b1, 32'h8000, MEM_READ, SIZE_HALF, 32'h104, 32'd0, CAUSE_NONE}},
    '{'{CMD_LW, 5'd8, 5'd0, 5'd0, 32'h108, 3'd4, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{STATUS_OK, 32'd32, 1'b1, 32'hFFFF_FFFF, MEM_READ, SIZE_WORD, 32'h108, 32'd0, CAUSE_NONE}},
    // bus refusal on a load: no writeback, PC held
    '{'{CMD_LW, 5'd9, 5'd0, 5'd0, 32'h200, 3'd4, 32'h1234_5678, 1'b0}, 1'b1,
      '{STATUS_FAULT, 32'd32, 1'b0, 32'd0, MEM_READ, SIZE_WORD, 32'h200, 32'd0, CAUSE_NONE}},
    '{'{CMD_SB, 5'd0, 5'd1, 5'd2, 32'h7FFF_FFFF, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_SH, 5'd0, 5'd3, 5'd8, 32'h1, 3'd4, 32'd0, 1'b0}, 1'b0, NO_CHECK},
    '{'{CMD_SW, 5'd0, 5'd0, 5'd3, 32'hFFFF_FFFC, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_ECALL, 5'd1, 5'd1, 5'd2, 32'd0, 3'd4, 32'd0, 1'b1}, 1'b1,
      '{STATUS_TRAP, 32'd40, 1'b0, 32'd0, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_ECALL_M}},
    '{'{CMD_EBREAK, 5'd1, 5'd1, 5'd2, 32'd0, 3'd2, 32'd0, 1'b1}, 1'b1,
      '{STATUS_TRAP, 32'd40, 1'b0, 32'd0, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_BREAKPOINT}},
    '{'{CMD_UNKNOWN_HI, 5'd1, 5'd1, 5'd2, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{STATUS_FAULT, 32'd40, 1'b0, 32'd0, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_NONE}},
    '{'{CMD_WFI, 5'd1, 5'd0, 5'd0, 32'd0, 3'd4, 32'd0, 1'b1}, 1'b1,
      '{STATUS_WFI, 32'd44, 1'b0, 32'd0, MEM_NONE, SIZE_BYTE, 32'd0, 32'd0, CAUSE_NONE}},
    '{'{CMD_FENCE, 5'd1, 5'd0, 5'd0, 32'd0, 3'd7, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_FENCE, 5'd1, 5'd0, 5'd0, 32'd0, 3'd0, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_JAL, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFF8, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_JALR, 5'd10, 5'd2, 5'd0, 32'd0, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_BEQ, 5'd0, 5'd0, 5'd0, 32'h8000_0000, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_BLTU, 5'd0, 5'd2, 5'd3, 32'h10, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_SRAI, 5'd11, 5'd4, 5'd0, 32'hFFFF_FFFF, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    '{'{CMD_SLL, 5'd12, 5'd2, 5'd3, 32'd0, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK},
    // write to x0 is dropped
    '{'{CMD_ADD, 5'd0, 5'd2, 5'd3, 32'd0, 3'd4, 32'd0, 1'b1}, 1'b0, NO_CHECK}
  };

  rv32i_execute_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .dest_index_i    (dest_index_i),
    .src1_index_i    (src1_index_i),
    .src2_index_i    (src2_index_i),
    .immediate_i     (immediate_i),
    .insn_length_i   (insn_length_i),
    .load_data_i     (load_data_i),
    .bus_ok_i        (bus_ok_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .new_pc_o        (new_pc_o),
    .reg_written_o   (reg_written_o),
    .written_value_o (written_value_o),
    .mem_op_o        (mem_op_o),
    .mem_size_o      (mem_size_o),
    .mem_address_o   (mem_address_o),
    .store_value_o   (store_value_o),
    .trap_cause_o    (trap_cause_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] reg_value(input logic [4:0] idx);
    return (idx != 5'd0 && idx < REG_COUNT) ? arch_regs[idx] : 32'd0;
  endfunction

  // Execute one instruction against the bench's state and return its result
  function automatic exec_res_t execute_insn(input insn_t x);
    exec_res_t   r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] target;
    logic [31:0] npc;
    bit          writes;
    r      = '0;
    a      = reg_value(x.rs1);
    b      = reg_value(x.rs2);
    target = arch_pc + x.imm;
    npc    = arch_pc + {29'd0, x.len};
    writes = 1'b0;
    r.status = STATUS_OK;
    r.mop    = MEM_NONE;
    r.msize  = SIZE_BYTE;
    r.cause  = CAUSE_NONE;
    case (x.cmd)
      CMD_LUI:   begin writes = 1'b1; r.wval = x.imm; end
      CMD_AUIPC: begin writes = 1'b1; r.wval = target; end
      CMD_JAL:   begin writes = 1'b1; r.wval = npc; npc = target; end
      CMD_JALR:  begin writes = 1'b1; r.wval = npc; npc = (a + x.imm) & ~32'd1; end
      CMD_BEQ:   if (a == b) npc = target;
      CMD_BNE:   if (a != b) npc = target;
      CMD_BLT:   if ($signed(a) < $signed(b)) npc = target;
      CMD_BGE:   if ($signed(a) >= $signed(b)) npc = target;
      CMD_BLTU:  if (a < b) npc = target;
      CMD_BGEU:  if (a >= b) npc = target;
      CMD_LB, CMD_LBU, CMD_LH, CMD_LHU, CMD_LW: begin
        r.mop   = MEM_READ;
        r.maddr = a + x.imm;
        case (x.cmd)
          CMD_LB, CMD_LBU: r.msize = SIZE_BYTE;
          CMD_LH, CMD_LHU: r.msize = SIZE_HALF;
          default:         r.msize = SIZE_WORD;
        endcase
        if (!x.ok) begin
          r.status = STATUS_FAULT;
          npc      = arch_pc;
        end else begin
          writes = 1'b1;
          case (x.cmd)
            CMD_LB:  r.wval = {{24{x.ldata[7]}}, x.ldata[7:0]};
            CMD_LBU: r.wval = {24'd0, x.ldata[7:0]};
            CMD_LH:  r.wval = {{16{x.ldata[15]}}, x.ldata[15:0]};
            CMD_LHU: r.wval = {16'd0, x.ldata[15:0]};
            default: r.wval = x.ldata;
          endcase
        end
      end
      CMD_SB, CMD_SH, CMD_SW: begin
        r.mop   = MEM_WRITE;
        r.maddr = a + x.imm;
        case (x.cmd)
          CMD_SB:  begin r.msize = SIZE_BYTE; r.sval = {24'd0, b[7:0]}; end
          CMD_SH:  begin r.msize = SIZE_HALF; r.sval = {16'd0, b[15:0]}; end
          default: begin r.msize = SIZE_WORD; r.sval = b; end
        endcase
        if (!x.ok) begin
          r.status = STATUS_FAULT;
          npc      = arch_pc;
        end
      end
      CMD_ADDI:  begin writes = 1'b1; r.wval = a + x.imm; end
      CMD_SLTI:  begin writes = 1'b1; r.wval = {31'd0, $signed(a) < $signed(x.imm)}; end
      CMD_SLTIU: begin writes = 1'b1; r.wval = {31'd0, a < x.imm}; end
      CMD_XORI:  begin writes = 1'b1; r.wval = a ^ x.imm; end
      CMD_ORI:   begin writes = 1'b1; r.wval = a | x.imm; end
      CMD_ANDI:  begin writes = 1'b1; r.wval = a & x.imm; end
      CMD_SLLI:  begin writes = 1'b1; r.wval = a << x.imm[4:0]; end
      CMD_SRLI:  begin writes = 1'b1; r.wval = a >> x.imm[4:0]; end
      CMD_SRAI:  begin writes = 1'b1; r.wval = $signed(a) >>> x.imm[4:0]; end
      CMD_ADD:   begin writes = 1'b1; r.wval = a + b; end
      CMD_SUB:   begin writes = 1'b1; r.wval = a - b; end
      CMD_SLL:   begin writes = 1'b1; r.wval = a << b[4:0]; end
      CMD_SLT:   begin writes = 1'b1; r.wval = {31'd0, $signed(a) < $signed(b)}; end
      CMD_SLTU:  begin writes = 1'b1; r.wval = {31'd0, a < b}; end
      CMD_XOR:   begin writes = 1'b1; r.wval = a ^ b; end
      CMD_SRL:   begin writes = 1'b1; r.wval = a >> b[4:0]; end
      CMD_SRA:   begin writes = 1'b1; r.wval = $signed(a) >>> b[4:0]; end
      CMD_OR:    begin writes = 1'b1; r.wval = a | b; end
      CMD_AND:   begin writes = 1'b1; r.wval = a & b; end
      CMD_FENCE: ;
      CMD_ECALL: begin
        r.status = STATUS_TRAP;
        npc      = arch_pc;
        // the reserved mode falls through to the machine cause
        case (priv_mode)
          PRIV_USER:       r.cause = CAUSE_ECALL_U;
          PRIV_SUPERVISOR: r.cause = CAUSE_ECALL_S;
          default:         r.cause = CAUSE_ECALL_M;
        endcase
      end
      CMD_EBREAK: begin
        r.status = STATUS_TRAP;
        npc      = arch_pc;
        r.cause  = CAUSE_BREAKPOINT;
      end
      CMD_WFI:   r.status = STATUS_WFI;
      default: begin
        r.status = STATUS_FAULT;
        npc      = arch_pc;
      end
    endcase
    if (writes && x.rd != 5'd0 && x.rd < REG_COUNT) begin
      arch_regs[x.rd] = r.wval;
      r.wr            = 1'b1;
    end else begin
      r.wval = 32'd0;
    end
    r.npc   = npc;
    arch_pc = npc;
    return r;
  endfunction

  // Favour a few low registers so results feed later operands
  function automatic logic [4:0] pick_index();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
  endfunction

  function automatic insn_t random_insn();
    insn_t       x;
    logic [31:0] raw;
    raw   = $urandom();
    x.cmd = ($urandom_range(99) < 4) ? 6'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO))
                                     : 6'($urandom_range(CMD_WFI));
    x.rd  = pick_index();
    x.rs1 = pick_index();
    x.rs2 = ($urandom_range(7) == 0) ? x.rs1 : pick_index();
    case ($urandom_range(3))
      0: x.imm = raw;
      1: x.imm = {{20{raw[11]}}, raw[11:0]};
      2: begin
        case ($urandom_range(5))
          0:       x.imm = 32'h0000_0000;
          1:       x.imm = 32'h7FFF_FFFF;
          2:       x.imm = 32'h8000_0000;
          3:       x.imm = 32'hFFFF_FFFF;
          4:       x.imm = 32'd1;
          default: x.imm = 32'd31;
        endcase
      end
      default: x.imm = {raw[31:12], 12'd0};
    endcase
    if ($urandom_range(15) == 0) x.len = 3'($urandom_range(7));
    else                         x.len = $urandom_range(1) ? 3'd4 : 3'd2;
    x.ldata = $urandom();
    x.ok    = ($urandom_range(9) != 0);
    return x;
  endfunction

  function automatic string describe_retire(input exec_res_t r);
    return $sformatf("st=%0d pc=%h wr=%0d val=%h mem=%0d/%0d addr=%h sval=%h cause=%0d",
                     r.status, r.npc, r.wr, r.wval, r.mop, r.msize, r.maddr, r.sval,
                     r.cause);
  endfunction

  // Offer one instruction, hold it until the beat, then record its result
  task automatic issue_insn(input insn_t x, input bit typed, input exec_res_t typed_res);
    exec_res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    command_i     <= x.cmd;
    dest_index_i  <= x.rd;
    src1_index_i  <= x.rs1;
    src2_index_i  <= x.rs2;
    immediate_i   <= x.imm;
    insn_length_i <= x.len;
    load_data_i   <= x.ldata;
    bus_ok_i      <= x.ok;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = execute_insn(x);
    predicted_retires.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_retires.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_programme(input logic [1:0] mode, input int count);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    priv_mode  = mode;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) hold_request = 1'b1;
      if (i == 2 * count / 3) settle();
      issue_insn(random_insn(), 1'b0, NO_CHECK);
    end
    settle();
  endtask

  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        // long back-pressure: let the unit fill and stall its input
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    exec_res_t got;
    exec_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o);
      got.npc    = new_pc_o;
      got.wr     = reg_written_o;
      got.wval   = written_value_o;
      got.mop    = mem_op_e'(mem_op_o);
      got.msize  = mem_size_e'(mem_size_o);
      got.maddr  = mem_address_o;
      got.sval   = store_value_o;
      got.cause  = trap_cause_o;
      if (predicted_retires.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d with nothing outstanding: %s", retired, describe_retire(got));
      end else begin
        want = predicted_retires.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d mismatch", retired);
            $display("  expected %s", describe_retire(want));
            $display("  actual   %s", describe_retire(got));
          end
        end
      end
      retired++;
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = PRIV_MACHINE;
    in_valid_i    = 1'b0;
    command_i     = CMD_FENCE;
    dest_index_i  = '0;
    src1_index_i  = '0;
    src2_index_i  = '0;
    immediate_i   = '0;
    insn_length_i = 3'd4;
    load_data_i   = '0;
    bus_ok_i      = 1'b1;
    foreach (arch_regs[i]) arch_regs[i] = 32'd0;
    arch_pc   = START_ADDRESS;
    priv_mode = PRIV_MACHINE;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      issue_insn(directed_rows[i].insn, directed_rows[i].typed, directed_rows[i].res);
    settle();

    run_programme(PRIV_USER, 350);
    send_gap_pct   = 65;
    recv_stall_pct = 9;
    run_programme(PRIV_SUPERVISOR, 350);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_programme(PRIV_RESERVED, 175);
    run_programme(PRIV_MACHINE, 175);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### rv32i_execute_unit.f
+incdir+rtl/core
rtl/core/rv32i_eu_pkg.sv
rtl/core/rv32i_eu_exec.sv
rtl/core/rv32i_execute_unit.sv
rtl/core/rv32i_eu_checker.sv
bench/testbench.sv
